// ===== rtl/p2i_pkg.sv =====
// ============================================================================
// p2i_pkg
// Shared types and constants for the postfix-to-infix converter.
// ============================================================================
package p2i_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNKNOWN  = 3'd1;
    localparam logic [2:0] ST_MISSING  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    // Character constants
    localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
    localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
    localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
    localparam logic [7:0] CH_ADD   = 8'h2B;  // '+'
    localparam logic [7:0] CH_SUB   = 8'h2D;  // '-'
    localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_END  = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] in_char;
    } item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
        logic [2:0] status;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_B,
        S_SCAN_A,
        S_SCAN_E,
        S_OP_CLOSE,
        S_COPY_B,
        S_COPY_B_END,
        S_OP_SYM,
        S_COPY_A,
        S_COPY_A_END,
        S_OP_OPEN,
        S_EMIT_RD,
        S_EMIT_WAIT,
        S_ERR
    } state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_TOP_M1,
        PTR_RD_M1,
        PTR_RD,
        PTR_DEC,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_PUSH,
        WR_CLOSE,
        WR_SYM,
        WR_OPEN,
        WR_COPY1,
        WR_COPY2
    } wr_op_t;

    typedef enum logic [1:0] {
        TOP_HOLD,
        TOP_INC,
        TOP_ADD3,
        TOP_SA
    } top_op_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_ERR,
        OUT_CHAR
    } out_op_t;

    typedef struct packed {
        logic       load_in;
        logic       rd;
        logic       depth_clr;
        logic       save_sb;
        logic       save_sa;
        ptr_op_t    ptr_op;
        wr_op_t     wr_op;
        top_op_t    top_op;
        out_op_t    out_op;
        logic [2:0] err_status;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic is_digit;
        logic is_op;
        logic top_zero;
        logic top_full;
        logic op_ovf;
        logic found;
        logic rd_addr_zero;
        logic ptr_eq_sb;
        logic ptr_eq_sa;
        logic emit_last;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/p2i_dp.sv =====
// ============================================================================
// p2i_dp
// Datapath: character stack memory, stack pointers, paren scan counter and
// the result register.
// ============================================================================
module p2i_dp #(
    parameter int STACK_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  p2i_pkg::item_t    item,
    input  p2i_pkg::cmd_t     cmd,
    output p2i_pkg::stat_t    stat,
    output p2i_pkg::result_t  result,
    output logic              result_valid,
    input  logic              result_stall
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int TW = $clog2(STACK_DEPTH + 1);

    logic [7:0]    mem [STACK_DEPTH];

    logic [TW-1:0] top_reg, top_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] sa_reg, sb_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [7:0]    rd_data_reg;
    logic          rd_valid_reg;
    logic [TW-1:0] depth_reg, depth_next, depth_eval;
    logic [7:0]    ch_reg;
    logic          mode_reg;

    p2i_pkg::result_t result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [TW-1:0] top_m1;
    logic [TW:0]   top_p2;
    logic [TW+1:0] top_p3;
    logic [TW:0]   rd_addr_p1;
    logic          out_free;

    assign top_m1     = top_reg - TW'(1);
    assign top_p2     = {1'b0, top_reg} + (TW+1)'(2);
    assign top_p3     = {2'b00, top_reg} + (TW+2)'(3);
    assign rd_addr_p1 = (TW+1)'(rd_addr_reg) + (TW+1)'(1);
    assign out_free   = !result_valid_reg || !result_stall;

    // paren count after the character just read
    always_comb
    begin
        depth_eval = depth_reg;
        if (rd_data_reg == p2i_pkg::CH_CLOSE)
        begin
            depth_eval = depth_reg + TW'(1);
        end
        else if (rd_data_reg == p2i_pkg::CH_OPEN)
        begin
            depth_eval = depth_reg - TW'(1);
        end
    end

    always_comb
    begin
        if (cmd.depth_clr)
        begin
            depth_next = '0;
        end
        else if (rd_valid_reg)
        begin
            depth_next = depth_eval;
        end
        else
        begin
            depth_next = depth_reg;
        end
    end

    always_comb
    begin
        stat.mode         = mode_reg;
        stat.is_digit     = (ch_reg >= p2i_pkg::CH_ZERO) && (ch_reg <= p2i_pkg::CH_NINE);
        stat.is_op        = (ch_reg == p2i_pkg::CH_MUL) || (ch_reg == p2i_pkg::CH_ADD) ||
                            (ch_reg == p2i_pkg::CH_SUB) || (ch_reg == p2i_pkg::CH_DIV);
        stat.top_zero     = (top_reg == '0);
        stat.top_full     = (top_reg == TW'(STACK_DEPTH));
        stat.op_ovf       = (top_p3 > (TW+2)'(STACK_DEPTH));
        stat.found        = rd_valid_reg && (depth_eval == '0);
        stat.rd_addr_zero = (rd_addr_reg == '0);
        stat.ptr_eq_sb    = (ptr_reg == sb_reg);
        stat.ptr_eq_sa    = (ptr_reg == sa_reg);
        stat.emit_last    = (rd_addr_p1 == {1'b0, top_reg});
        stat.out_free     = out_free;
    end

    always_comb
    begin
        unique case (cmd.ptr_op)
            p2i_pkg::PTR_TOP_M1: ptr_next = top_m1[AW-1:0];
            p2i_pkg::PTR_RD_M1:  ptr_next = rd_addr_reg - AW'(1);
            p2i_pkg::PTR_RD:     ptr_next = rd_addr_reg;
            p2i_pkg::PTR_DEC:    ptr_next = ptr_reg - AW'(1);
            p2i_pkg::PTR_INC:    ptr_next = ptr_reg + AW'(1);
            default:             ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.top_op)
            p2i_pkg::TOP_INC:  top_next = top_reg + TW'(1);
            p2i_pkg::TOP_ADD3: top_next = top_reg + TW'(3);
            p2i_pkg::TOP_SA:   top_next = TW'(sa_reg);
            default:           top_next = top_reg;
        endcase
    end

    // copy writes land in the cycle after their read, hence the rd_valid gate
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = ch_reg;
        unique case (cmd.wr_op)
            p2i_pkg::WR_PUSH:
            begin
                wr_addr = top_reg[AW-1:0];
            end
            p2i_pkg::WR_CLOSE:
            begin
                wr_addr = top_p2[AW-1:0];
                wr_data = p2i_pkg::CH_CLOSE;
            end
            p2i_pkg::WR_SYM:
            begin
                wr_addr = sb_reg + AW'(1);
            end
            p2i_pkg::WR_OPEN:
            begin
                wr_addr = sa_reg;
                wr_data = p2i_pkg::CH_OPEN;
            end
            p2i_pkg::WR_COPY1:
            begin
                wr_en   = rd_valid_reg;
                wr_addr = rd_addr_reg + AW'(1);
                wr_data = rd_data_reg;
            end
            p2i_pkg::WR_COPY2:
            begin
                wr_en   = rd_valid_reg;
                wr_addr = rd_addr_reg + AW'(2);
                wr_data = rd_data_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        unique case (cmd.out_op)
            p2i_pkg::OUT_ERR:
            begin
                result_next.out_char = 8'h00;
                result_next.last     = 1'b1;
                result_next.status   = cmd.err_status;
                result_valid_next    = 1'b1;
            end
            p2i_pkg::OUT_CHAR:
            begin
                result_next.out_char = rd_data_reg;
                result_next.last     = stat.emit_last;
                result_next.status   = p2i_pkg::ST_OK;
                result_valid_next    = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[ptr_reg];
            rd_addr_reg <= ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        depth_reg  <= depth_next;
        result_reg <= result_next;
        if (cmd.save_sb)
        begin
            sb_reg <= rd_addr_reg;
        end
        if (cmd.save_sa)
        begin
            sa_reg <= rd_addr_reg;
        end
        if (cmd.load_in)
        begin
            ch_reg   <= item.in_char;
            mode_reg <= item.mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg          <= '0;
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg          <= top_next;
            rd_valid_reg     <= cmd.rd;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== rtl/p2i_ctrl.sv =====
// ============================================================================
// p2i_ctrl
// Controller: sequences scans, in-place shifts and result emission.
// ============================================================================
module p2i_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  p2i_pkg::stat_t  stat,
    output p2i_pkg::cmd_t   cmd
);

    p2i_pkg::state_t state_reg, state_next;
    logic [2:0]      err_reg, err_next;

    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        unique case (state_reg)
            p2i_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = p2i_pkg::S_DECODE;
                end
            end
            p2i_pkg::S_DECODE:
            begin
                if (stat.mode == p2i_pkg::MODE_END)
                begin
                    if (stat.top_zero)
                    begin
                        err_next   = p2i_pkg::ST_EMPTY;
                        state_next = p2i_pkg::S_ERR;
                    end
                    else
                    begin
                        state_next = p2i_pkg::S_SCAN_E;
                    end
                end
                else if (stat.is_digit)
                begin
                    if (stat.top_full)
                    begin
                        err_next   = p2i_pkg::ST_OVERFLOW;
                        state_next = p2i_pkg::S_ERR;
                    end
                    else
                    begin
                        state_next = p2i_pkg::S_IDLE;
                    end
                end
                else if (stat.is_op)
                begin
                    if (stat.top_zero)
                    begin
                        err_next   = p2i_pkg::ST_MISSING;
                        state_next = p2i_pkg::S_ERR;
                    end
                    else
                    begin
                        state_next = p2i_pkg::S_SCAN_B;
                    end
                end
                else
                begin
                    err_next   = p2i_pkg::ST_UNKNOWN;
                    state_next = p2i_pkg::S_ERR;
                end
            end
            p2i_pkg::S_SCAN_B:
            begin
                if (stat.found)
                begin
                    if (stat.rd_addr_zero)
                    begin
                        err_next   = p2i_pkg::ST_MISSING;
                        state_next = p2i_pkg::S_ERR;
                    end
                    else
                    begin
                        state_next = p2i_pkg::S_SCAN_A;
                    end
                end
            end
            p2i_pkg::S_SCAN_A:
            begin
                if (stat.found)
                begin
                    if (stat.op_ovf)
                    begin
                        err_next   = p2i_pkg::ST_OVERFLOW;
                        state_next = p2i_pkg::S_ERR;
                    end
                    else
                    begin
                        state_next = p2i_pkg::S_OP_CLOSE;
                    end
                end
            end
            p2i_pkg::S_SCAN_E:
            begin
                if (stat.found)
                begin
                    state_next = p2i_pkg::S_EMIT_RD;
                end
            end
            p2i_pkg::S_OP_CLOSE:   state_next = p2i_pkg::S_COPY_B;
            p2i_pkg::S_COPY_B:
            begin
                if (stat.ptr_eq_sb)
                begin
                    state_next = p2i_pkg::S_COPY_B_END;
                end
            end
            p2i_pkg::S_COPY_B_END: state_next = p2i_pkg::S_OP_SYM;
            p2i_pkg::S_OP_SYM:     state_next = p2i_pkg::S_COPY_A;
            p2i_pkg::S_COPY_A:
            begin
                if (stat.ptr_eq_sa)
                begin
                    state_next = p2i_pkg::S_COPY_A_END;
                end
            end
            p2i_pkg::S_COPY_A_END: state_next = p2i_pkg::S_OP_OPEN;
            p2i_pkg::S_OP_OPEN:    state_next = p2i_pkg::S_IDLE;
            p2i_pkg::S_EMIT_RD:    state_next = p2i_pkg::S_EMIT_WAIT;
            p2i_pkg::S_EMIT_WAIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.emit_last ? p2i_pkg::S_IDLE : p2i_pkg::S_EMIT_RD;
                end
            end
            p2i_pkg::S_ERR:
            begin
                if (stat.out_free)
                begin
                    state_next = p2i_pkg::S_IDLE;
                end
            end
            default:               state_next = p2i_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.ptr_op     = p2i_pkg::PTR_HOLD;
        cmd.wr_op      = p2i_pkg::WR_NONE;
        cmd.top_op     = p2i_pkg::TOP_HOLD;
        cmd.out_op     = p2i_pkg::OUT_NONE;
        cmd.err_status = err_reg;
        item_stall     = 1'b1;
        unique case (state_reg)
            p2i_pkg::S_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.load_in = item_valid;
            end
            p2i_pkg::S_DECODE:
            begin
                cmd.ptr_op    = p2i_pkg::PTR_TOP_M1;
                cmd.depth_clr = 1'b1;
                if (stat.mode == p2i_pkg::MODE_CHAR && stat.is_digit && !stat.top_full)
                begin
                    cmd.wr_op  = p2i_pkg::WR_PUSH;
                    cmd.top_op = p2i_pkg::TOP_INC;
                end
            end
            // scans read one entry per cycle downward; read data is registered and returns in the next cycle
            p2i_pkg::S_SCAN_B:
            begin
                if (stat.found)
                begin
                    cmd.save_sb   = 1'b1;
                    cmd.ptr_op    = p2i_pkg::PTR_RD_M1;
                    cmd.depth_clr = 1'b1;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    cmd.ptr_op = p2i_pkg::PTR_DEC;
                end
            end
            p2i_pkg::S_SCAN_A:
            begin
                if (stat.found)
                begin
                    cmd.save_sa = 1'b1;
                    cmd.ptr_op  = p2i_pkg::PTR_TOP_M1;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    cmd.ptr_op = p2i_pkg::PTR_DEC;
                end
            end
            p2i_pkg::S_SCAN_E:
            begin
                if (stat.found)
                begin
                    cmd.save_sa = 1'b1;
                    cmd.ptr_op  = p2i_pkg::PTR_RD;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    cmd.ptr_op = p2i_pkg::PTR_DEC;
                end
            end
            p2i_pkg::S_OP_CLOSE:
            begin
                cmd.wr_op = p2i_pkg::WR_CLOSE;
            end
            // copies run top-down so no source is overwritten before it is read
            p2i_pkg::S_COPY_B:
            begin
                cmd.rd     = 1'b1;
                cmd.ptr_op = p2i_pkg::PTR_DEC;
                cmd.wr_op  = p2i_pkg::WR_COPY2;
            end
            p2i_pkg::S_COPY_B_END:
            begin
                cmd.wr_op = p2i_pkg::WR_COPY2;
            end
            p2i_pkg::S_OP_SYM:
            begin
                cmd.wr_op = p2i_pkg::WR_SYM;
            end
            p2i_pkg::S_COPY_A:
            begin
                cmd.rd     = 1'b1;
                cmd.ptr_op = p2i_pkg::PTR_DEC;
                cmd.wr_op  = p2i_pkg::WR_COPY1;
            end
            p2i_pkg::S_COPY_A_END:
            begin
                cmd.wr_op = p2i_pkg::WR_COPY1;
            end
            p2i_pkg::S_OP_OPEN:
            begin
                cmd.wr_op  = p2i_pkg::WR_OPEN;
                cmd.top_op = p2i_pkg::TOP_ADD3;
            end
            p2i_pkg::S_EMIT_RD:
            begin
                cmd.rd = 1'b1;
            end
            p2i_pkg::S_EMIT_WAIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_op = p2i_pkg::OUT_CHAR;
                    cmd.ptr_op = p2i_pkg::PTR_INC;
                    if (stat.emit_last)
                    begin
                        cmd.top_op = p2i_pkg::TOP_SA;
                    end
                end
            end
            p2i_pkg::S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_op = p2i_pkg::OUT_ERR;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= p2i_pkg::S_IDLE;
            err_reg   <= p2i_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== rtl/postfix_to_infix_converter.sv =====
// A digit is pushed directly; an operator takes two paren-scan passes (B, then A)
// and two in-place shift passes (B, then A) over the stack memory.
// An end item scans the top expression, then emits it one character at a time (read, then output once free).
// Throughput: one item at a time, input stalled until the current item is done.
// Reset: stack empty (top = 0), no result pending; stack memory is not cleared.
// ============================================================================
// postfix_to_infix_converter
// Converts reverse Polish characters into fully parenthesized infix text.
// ============================================================================
module postfix_to_infix_converter #(
    parameter int STACK_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  p2i_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output p2i_pkg::result_t  result
);

    p2i_pkg::cmd_t  cmd;
    p2i_pkg::stat_t stat;

    p2i_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    p2i_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

// ===== tb/postfix_to_infix_converter_checker.sv =====
// ============================================================================
// postfix_to_infix_converter_checker
// Watches both channels of the converter, keeps its own copy of the infix
// text stack, predicts every result and compares each result transfer with
// the oldest prediction.
// ============================================================================
module postfix_to_infix_converter_checker #(
    parameter int DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  p2i_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  p2i_pkg::result_t result,
    output int               fail_count,
    output int               pending
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]       text [DEPTH];
    int               text_top = 0;
    p2i_pkg::result_t infix_queue [$];
    int               mismatches = 0;

    // Start of the expression whose last character sits just below stop_pos.
    function automatic bit expr_start(input int stop_pos, output int start_pos);
        int i;
        int depth;
        i = stop_pos;
        depth = 0;
        if (stop_pos == 0 || stop_pos > DEPTH)
            return 1'b0;
        do
        begin
            i = i - 1;
            if (text[i] == p2i_pkg::CH_CLOSE)
                depth = depth + 1;
            else if (text[i] == p2i_pkg::CH_OPEN)
                depth = depth - 1;
        end while (depth > 0 && i > 0);
        if (depth > 0)
            return 1'b0;
        start_pos = i;
        return 1'b1;
    endfunction

    function automatic void expect_out(input logic [7:0] c, input logic l,
                                       input logic [2:0] s);
        p2i_pkg::result_t r;
        r.out_char = c;
        r.last     = l;
        r.status   = s;
        infix_queue.push_back(r);
    endfunction

    function automatic void convert_item(input p2i_pkg::item_t it);
        int sa;
        int sb;
        int n;
        int k;
        logic [7:0] merged [DEPTH];
        if (it.mode == p2i_pkg::MODE_END)
        begin
            if (text_top == 0 || !expr_start(text_top, sa))
                expect_out(8'h00, 1'b1, p2i_pkg::ST_EMPTY);
            else
            begin
                n = text_top - sa;
                for (k = 0; k < n; k++)
                    expect_out(text[sa + k], k == n - 1, p2i_pkg::ST_OK);
                text_top = sa;
            end
        end
        else if (it.in_char >= p2i_pkg::CH_ZERO && it.in_char <= p2i_pkg::CH_NINE)
        begin
            if (text_top >= DEPTH)
                expect_out(8'h00, 1'b1, p2i_pkg::ST_OVERFLOW);
            else
            begin
                text[text_top] = it.in_char;
                text_top = text_top + 1;
            end
        end
        else if (it.in_char == p2i_pkg::CH_MUL || it.in_char == p2i_pkg::CH_ADD ||
                 it.in_char == p2i_pkg::CH_SUB || it.in_char == p2i_pkg::CH_DIV)
        begin
            if (!expr_start(text_top, sb) || !expr_start(sb, sa))
                expect_out(8'h00, 1'b1, p2i_pkg::ST_MISSING);
            else if (text_top + 3 > DEPTH)
                expect_out(8'h00, 1'b1, p2i_pkg::ST_OVERFLOW);
            else
            begin
                n = 0;
                merged[n] = p2i_pkg::CH_OPEN;
                n = n + 1;
                for (k = sa; k < sb; k++)
                begin
                    merged[n] = text[k];
                    n = n + 1;
                end
                merged[n] = it.in_char;
                n = n + 1;
                for (k = sb; k < text_top; k++)
                begin
                    merged[n] = text[k];
                    n = n + 1;
                end
                merged[n] = p2i_pkg::CH_CLOSE;
                n = n + 1;
                for (k = 0; k < n; k++)
                    text[sa + k] = merged[k];
                text_top = sa + n;
            end
        end
        else
            expect_out(8'h00, 1'b1, p2i_pkg::ST_UNKNOWN);
    endfunction

    always @(posedge clk)
    begin
        p2i_pkg::result_t want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                convert_item(item);
            if (result_valid && !result_stall)
            begin
                if (infix_queue.size() == 0)
                begin
                    $error("result transfer with nothing expected: %h", result);
                    mismatches++;
                end
                else
                begin
                    want = infix_queue.pop_front();
                    if (result.out_char !== want.out_char)
                    begin
                        $error("out_char: expected %h, actual %h",
                               want.out_char, result.out_char);
                        mismatches++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %b, actual %b", want.last, result.last);
                        mismatches++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, result.status);
                        mismatches++;
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= infix_queue.size();
    end

endmodule

// ===== tb/postfix_to_infix_converter_tb.sv =====
// ============================================================================
// postfix_to_infix_converter_tb
// Feeds the converter reverse Polish streams: directed corner cases, then
// random well-formed expressions mixed with noise, stack fills and stray
// end items, under three idling mixes and one long result hold-off.
// ============================================================================
module postfix_to_infix_converter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 64;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_WAIT  = 400;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    p2i_pkg::item_t   in_item      = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    p2i_pkg::result_t result;

    int fail_count;
    int pending;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;
    int sent        = 0;

    // lengths of the expressions currently on the block's stack, bottom first
    int expr_lens [$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    postfix_to_infix_converter #(
        .STACK_DEPTH (DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (in_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    postfix_to_infix_converter_checker #(
        .DEPTH (DEPTH)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (in_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                result_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    function automatic int held_chars();
        int sum;
        sum = 0;
        foreach (expr_lens[i])
            sum += expr_lens[i];
        return sum;
    endfunction

    // mirror of the stack occupancy, used only to steer the stimulus
    function automatic void note_item(input p2i_pkg::item_t it);
        int a;
        int b;
        if (it.mode == p2i_pkg::MODE_END)
        begin
            if (expr_lens.size() > 0)
                void'(expr_lens.pop_back());
        end
        else if (it.in_char >= p2i_pkg::CH_ZERO && it.in_char <= p2i_pkg::CH_NINE)
        begin
            if (held_chars() < DEPTH)
                expr_lens.push_back(1);
        end
        else if (it.in_char == p2i_pkg::CH_MUL || it.in_char == p2i_pkg::CH_ADD ||
                 it.in_char == p2i_pkg::CH_SUB || it.in_char == p2i_pkg::CH_DIV)
        begin
            if (expr_lens.size() >= 2 && held_chars() + 3 <= DEPTH)
            begin
                b = expr_lens.pop_back();
                a = expr_lens.pop_back();
                expr_lens.push_back(a + b + 3);
            end
        end
    endfunction

    function automatic logic [7:0] any_digit();
        return p2i_pkg::CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] any_op();
        case ($urandom_range(3))
            0: return p2i_pkg::CH_MUL;
            1: return p2i_pkg::CH_ADD;
            2: return p2i_pkg::CH_SUB;
            default: return p2i_pkg::CH_DIV;
        endcase
    endfunction

    task automatic send(input p2i_pkg::item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        in_item    <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent++;
        note_item(it);
    endtask

    task automatic send_char(input logic [7:0] c);
        p2i_pkg::item_t it;
        it.mode    = p2i_pkg::MODE_CHAR;
        it.in_char = c;
        send(it);
    endtask

    task automatic send_end(input logic [7:0] filler);
        p2i_pkg::item_t it;
        it.mode    = p2i_pkg::MODE_END;
        it.in_char = filler;
        send(it);
    endtask

    // random well-formed postfix expression with the given operand count
    task automatic send_expr(input int operands);
        int pushed;
        int live;
        pushed = 0;
        live = 0;
        while (pushed < operands || live > 1)
        begin
            if (pushed < operands && (live < 2 || $urandom_range(1) == 0))
            begin
                send_char(any_digit());
                pushed++;
                live++;
            end
            else
            begin
                send_char(any_op());
                live--;
            end
        end
    endtask

    task automatic drain();
        while (expr_lens.size() > 0)
            send_end(8'($urandom_range(255)));
    endtask

    // fill the stack to the top, hit both overflow cases, then empty it
    task automatic fill_stack();
        send_expr($urandom_range(8, 16));
        while (held_chars() < DEPTH)
            send_char(any_digit());
        send_char(any_digit());
        send_char(any_op());
        drain();
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        int pick;
        stop_at = sent + count;
        while (sent < stop_at)
        begin
            if (held_chars() > 44)
                drain();
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                if ($urandom_range(9) == 0)
                    send_expr($urandom_range(7, 16));
                else
                    send_expr($urandom_range(1, 6));
                if ($urandom_range(9) != 0)
                    send_end(8'($urandom_range(255)));
            end
            else if (pick < 85)
                send_char(8'($urandom_range(255)));
            else if (pick < 90)
                send_char(any_op());
            else if (pick < 97)
                send_end(8'($urandom_range(255)));
            else
                fill_stack();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 8;
        rx_idle_pct <= 48;

        // directed: empty end, missing operands, unknown characters, nesting
        send_end(8'hFF);
        send_char(p2i_pkg::CH_ADD);
        send_char(p2i_pkg::CH_ZERO);
        send_char(p2i_pkg::CH_MUL);
        send_char(p2i_pkg::CH_NINE);
        send_char(p2i_pkg::CH_SUB);
        send_end(8'h5A);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(p2i_pkg::CH_OPEN);
        send_char(p2i_pkg::CH_CLOSE);
        send_char(8'h2C);
        send_char(8'h2E);
        send_char(8'h3A);
        send_char(8'h37);
        send_char(8'h33);
        send_char(p2i_pkg::CH_DIV);
        send_char(8'h35);
        send_char(p2i_pkg::CH_ADD);
        send_char(8'h32);
        send_char(p2i_pkg::CH_MUL);
        send_end(8'h00);
        send_end(8'h00);

        fill_stack();
        random_phase(105);

        tx_idle_pct = 48;
        rx_idle_pct <= 8;
        random_phase(105);

        // no idling; receiver holds off while items keep coming
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req <= 1'b1;
        random_phase(105);

        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
